/* rtl/core/ccls_pkg.sv */
`timescale 1ns / 1ps
// ccls_pkg: shared types, register indexes, event codes and reset values
// for the cage climate and level supervisor; no dependencies
package ccls_pkg;

  localparam int TEMP_W   = 9;
  localparam int MARGIN_W = 6;
  localparam int EVENT_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN   = 2'd2;

  localparam logic [EVENT_W-1:0] EV_NONE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_OUT  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_BACK = 2'd2;

  localparam logic signed [TEMP_W-1:0] MIN_TEMP_RST = 9'sd20;
  localparam logic signed [TEMP_W-1:0] MAX_TEMP_RST = 9'sd80;
  localparam logic [MARGIN_W-1:0]      MARGIN_RST   = 6'd2;

  typedef struct packed {
    logic signed [TEMP_W-1:0] min_temp;
    logic signed [TEMP_W-1:0] max_temp;
    logic [MARGIN_W-1:0]      margin;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic                     food_present;
    logic                     low_level_ok;
    logic                     high_level_full;
  } item_t;

  typedef struct packed {
    logic food_alarm;
    logic water_alarm;
    logic climate_alarm;
    logic valve;
    logic water_lamp;
    logic fan;
    logic heater;
    logic cold_lamp;
    logic hot_lamp;
  } state_t;

  typedef struct packed {
    logic               motor_on;
    logic               valve_open;
    logic               fan_on;
    logic               heater_on;
    logic               food_lamp;
    logic               water_lamp;
    logic               cold_lamp;
    logic               hot_lamp;
    logic [EVENT_W-1:0] food_event;
    logic [EVENT_W-1:0] water_event;
    logic [EVENT_W-1:0] climate_event;
  } result_t;

endpackage

/* rtl/core/ccls_cfg_regs.sv */
`timescale 1ns / 1ps
// ccls_cfg_regs: temperature window and hysteresis margin registers
// depends on ccls_pkg
module ccls_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [ccls_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [ccls_pkg::CFG_DATA_W-1:0]   wr_data,
  output ccls_pkg::cfg_t                    cfg
);
  import ccls_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_MIN_TEMP: cfg_nxt.min_temp = $signed(wr_data[TEMP_W-1:0]);
        REG_MAX_TEMP: cfg_nxt.max_temp = $signed(wr_data[TEMP_W-1:0]);
        REG_MARGIN:   cfg_nxt.margin   = wr_data[MARGIN_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_temp <= MIN_TEMP_RST;
      cfg_r.max_temp <= MAX_TEMP_RST;
      cfg_r.margin   <= MARGIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/ccls_eval.sv */
`timescale 1ns / 1ps
// ccls_eval: one supervision pass, food, water and climate decisions
// depends on ccls_pkg
module ccls_eval (
  input  ccls_pkg::item_t   item,
  input  ccls_pkg::state_t  state,
  input  ccls_pkg::cfg_t    cfg,
  output ccls_pkg::state_t  state_nxt,
  output ccls_pkg::result_t result
);
  import ccls_pkg::*;

  localparam int WIDE_W = TEMP_W + 1;

  logic signed [WIDE_W-1:0] t_w;
  logic signed [WIDE_W-1:0] max_w;
  logic signed [WIDE_W-1:0] min_w;
  logic signed [WIDE_W-1:0] margin_w;
  logic signed [WIDE_W-1:0] fan_off_lim;
  logic signed [WIDE_W-1:0] heat_off_lim;

  assign t_w          = WIDE_W'(item.temperature);
  assign max_w        = WIDE_W'(cfg.max_temp);
  assign min_w        = WIDE_W'(cfg.min_temp);
  assign margin_w     = $signed({{(WIDE_W-MARGIN_W){1'b0}}, cfg.margin});
  assign fan_off_lim  = max_w - margin_w;
  assign heat_off_lim = min_w + margin_w;

  always_comb begin
    state_nxt            = state;
    result               = '0;
    result.food_event    = EV_NONE;
    result.water_event   = EV_NONE;
    result.climate_event = EV_NONE;

    // food
    result.motor_on  = !item.food_present;
    result.food_lamp = !item.food_present;
    if (!item.food_present) begin
      if (!state.food_alarm) begin
        result.food_event    = EV_OUT;
        state_nxt.food_alarm = 1'b1;
      end
    end else if (state.food_alarm) begin
      result.food_event    = EV_BACK;
      state_nxt.food_alarm = 1'b0;
    end

    // water, empty handling first then full handling
    if (!item.low_level_ok) begin
      state_nxt.water_lamp = 1'b1;
      state_nxt.valve      = 1'b1;
      if (!state.water_alarm) begin
        result.water_event    = EV_OUT;
        state_nxt.water_alarm = 1'b1;
      end
    end
    if (item.high_level_full) begin
      state_nxt.water_lamp = 1'b0;
      state_nxt.valve      = 1'b0;
      if (state_nxt.water_alarm && item.low_level_ok) begin
        result.water_event    = EV_BACK;
        state_nxt.water_alarm = 1'b0;
      end
    end

    // climate
    priority if (t_w > max_w) begin
      state_nxt.hot_lamp = 1'b1;
      state_nxt.fan      = 1'b1;
      state_nxt.heater   = 1'b0;
      if (!state.climate_alarm) begin
        result.climate_event    = EV_OUT;
        state_nxt.climate_alarm = 1'b1;
      end
    end else if (t_w < min_w) begin
      state_nxt.cold_lamp = 1'b1;
      state_nxt.heater    = 1'b1;
      state_nxt.fan       = 1'b0;
      if (!state.climate_alarm) begin
        result.climate_event    = EV_OUT;
        state_nxt.climate_alarm = 1'b1;
      end
    end else begin
      state_nxt.cold_lamp = 1'b0;
      state_nxt.hot_lamp  = 1'b0;
      if (t_w <= fan_off_lim) state_nxt.fan = 1'b0;
      if (t_w >= heat_off_lim) state_nxt.heater = 1'b0;
      if (state.climate_alarm && !state_nxt.fan && !state_nxt.heater) begin
        result.climate_event    = EV_BACK;
        state_nxt.climate_alarm = 1'b0;
      end
    end

    result.valve_open = state_nxt.valve;
    result.water_lamp = state_nxt.water_lamp;
    result.fan_on     = state_nxt.fan;
    result.heater_on  = state_nxt.heater;
    result.cold_lamp  = state_nxt.cold_lamp;
    result.hot_lamp   = state_nxt.hot_lamp;
  end

endmodule

/* rtl/core/cage_climate_level_supervisor.sv */
`timescale 1ns / 1ps
// cage_climate_level_supervisor: top level, input register, pass logic,
// supervisor state and result register; depends on ccls_pkg, ccls_cfg_regs, ccls_eval
// a transaction passes through the input register and then the result register before
// its result transaction is offered on out_valid
// throughput: one transaction per cycle while out_ready is high
// the state update and result capture share one cycle, set by the result register
// reset (synchronous, rst_n low): pipeline empty, all supervisor flags cleared,
// limits back to 20 / 80 half degrees and margin 2
module cage_climate_level_supervisor (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ccls_pkg::TEMP_W-1:0]   in_temperature,
  input  logic                                 in_food_present,
  input  logic                                 in_low_level_ok,
  input  logic                                 in_high_level_full,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_motor_on,
  output logic                                 out_valve_open,
  output logic                                 out_fan_on,
  output logic                                 out_heater_on,
  output logic                                 out_food_lamp,
  output logic                                 out_water_lamp,
  output logic                                 out_cold_lamp,
  output logic                                 out_hot_lamp,
  output logic [ccls_pkg::EVENT_W-1:0]         out_food_event,
  output logic [ccls_pkg::EVENT_W-1:0]         out_water_event,
  output logic [ccls_pkg::EVENT_W-1:0]         out_climate_event,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ccls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ccls_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ccls_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_valid_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t pass_result;
  result_t result_r;
  logic    out_valid_r;
  logic    advance;
  logic    in_fire;

  assign cfg_ready = 1'b1;

  ccls_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ccls_eval u_eval (
    .item      (item_r),
    .state     (state_r),
    .cfg       (cfg),
    .state_nxt (state_nxt),
    .result    (pass_result)
  );

  // result register free or draining this cycle
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !item_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      state_r      <= '0;
    end else begin
      if (in_ready) item_valid_r <= in_valid;
      if (advance) out_valid_r <= item_valid_r;
      if (advance && item_valid_r) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.temperature     <= in_temperature;
      item_r.food_present    <= in_food_present;
      item_r.low_level_ok    <= in_low_level_ok;
      item_r.high_level_full <= in_high_level_full;
    end
    if (advance && item_valid_r) result_r <= pass_result;
  end

  assign out_valid         = out_valid_r;
  assign out_motor_on      = result_r.motor_on;
  assign out_valve_open    = result_r.valve_open;
  assign out_fan_on        = result_r.fan_on;
  assign out_heater_on     = result_r.heater_on;
  assign out_food_lamp     = result_r.food_lamp;
  assign out_water_lamp    = result_r.water_lamp;
  assign out_cold_lamp     = result_r.cold_lamp;
  assign out_hot_lamp      = result_r.hot_lamp;
  assign out_food_event    = result_r.food_event;
  assign out_water_event   = result_r.water_event;
  assign out_climate_event = result_r.climate_event;

  // stall only when both stages hold a transaction
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (item_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with a free stage");

  // leaving the window always drives fan or heater
  a_climate_out_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_climate_event == EV_OUT) |-> (out_fan_on || out_heater_on))
    else $error("out of range event without fan or heater");

  // restored water implies closed valve and dark lamp
  a_water_back: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_water_event == EV_BACK) |-> (!out_valve_open && !out_water_lamp))
    else $error("water restored with valve open");

  // state only moves when a pass completes
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(advance && item_valid_r) |-> $stable(state_r))
    else $error("supervisor state changed without a pass");

endmodule
